// ===== hw/rtl/gaussian_elimination_solver_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GAUSSIAN_ELIMINATION_SOLVER_DEFINES_SVH
`define GAUSSIAN_ELIMINATION_SOLVER_DEFINES_SVH

// Check an implication on the rising clock edge, ignored while in reset.
`define GES_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, but also active during reset.
`define GES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/ges_pkg.sv =====
package ges_pkg;

   localparam int MaxOrder  = 8;
   localparam int ValueBits = 32;
   localparam int FracBits  = 16;
   localparam int NCols     = MaxOrder + 1;
   localparam int RowBits   = $clog2(MaxOrder);
   localparam int ColBits   = $clog2(NCols);
   localparam int AddrBits  = $clog2(MaxOrder * NCols);
   localparam int Depth     = MaxOrder * NCols;
   localparam int ProdBits  = 2 * ValueBits;
   localparam int DivBits   = ValueBits + FracBits;
   localparam int DivCntBits = $clog2(DivBits + 1);

   localparam logic signed [ValueBits-1:0] VMax = {1'b0, {(ValueBits-1){1'b1}}};
   localparam logic signed [ValueBits-1:0] VMin = {1'b1, {(ValueBits-1){1'b0}}};

   typedef logic signed [ValueBits-1:0] value_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_E_PIV,      // read pivot m[k][k]
      ST_E_PIVW,
      ST_E_RDA,      // read m[i][k]
      ST_E_RDAW,
      ST_E_DIV,      // c = m[i][k] / pivot
      ST_E_RDJ,      // read m[k][j]
      ST_E_RDJW,
      ST_E_MUL,      // p = c * m[k][j]
      ST_E_RDIJ,     // read m[i][j]
      ST_E_RDIJW,
      ST_E_WR,       // m[i][j] -= p
      ST_B_RDB,      // read m[i][n]
      ST_B_RDBW,
      ST_B_RDJ,      // read m[i][j]
      ST_B_RDJW,
      ST_B_MUL,
      ST_B_SUB,
      ST_B_RDD,      // read m[i][i]
      ST_B_RDDW,
      ST_B_DIV,
      ST_OUT
   } state_type;

   // Control from the sequencer to the arithmetic unit
   typedef struct packed {
      logic mul_start;
      logic div_start;
   } alu_ctl_type;

   typedef struct packed {
      logic busy;
   } alu_sts_type;

   function automatic value_type sat_sub(value_type a, value_type b);
      logic signed [ValueBits:0] d;
      d = {a[ValueBits-1], a} - {b[ValueBits-1], b};
      if (d[ValueBits] != d[ValueBits-1])
         return d[ValueBits] ? VMin : VMax;
      return d[ValueBits-1:0];
   endfunction

endpackage

// ===== hw/rtl/ges_alu.sv =====
// Shared fixed point unit: a registered multiply with saturation, and a
// restoring divider that produces one quotient bit a cycle.
module ges_alu
   import ges_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_ctl_type ctl,
   input  value_type   op_a,
   input  value_type   op_b,
   output alu_sts_type sts,
   output value_type   result
);

   localparam logic [ValueBits-1:0] MagMax = VMax;

   logic [ValueBits-1:0]  ma, mb;
   logic                  neg;
   logic [ProdBits-1:0]   prod;
   logic [ProdBits-1:0]   psh;

   logic                  busy_ff, busy_in;
   logic [DivCntBits-1:0] cnt_ff, cnt_in;
   logic [DivBits-1:0]    dvd_ff, dvd_in;
   logic [ValueBits:0]    rem_ff, rem_in;
   logic [ValueBits-1:0]  dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;
   value_type             res_ff, res_in;
   logic [ValueBits:0]    rsh;

   function automatic value_type make_signed(logic ng, logic ovf, logic [ValueBits-1:0] m);
      if (ovf || m > MagMax + {{(ValueBits-1){1'b0}}, ng})
         return ng ? VMin : VMax;
      return ng ? value_type'(-m) : value_type'(m);
   endfunction

   assign ma   = op_a[ValueBits-1] ? ValueBits'(-op_a) : op_a;
   assign mb   = op_b[ValueBits-1] ? ValueBits'(-op_b) : op_b;
   assign neg  = op_a[ValueBits-1] ^ op_b[ValueBits-1];
   assign prod = ProdBits'(ma) * ProdBits'(mb);
   assign psh  = prod >> FracBits;
   assign rsh  = {rem_ff[ValueBits-1:0], dvd_ff[DivBits-1]};

   // Divider steps and multiply capture
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (ctl.mul_start) begin
         res_in = make_signed(neg, |psh[ProdBits-1:ValueBits], psh[ValueBits-1:0]);
      end else if (ctl.div_start) begin
         busy_in = 1'b1;
         cnt_in  = DivCntBits'(DivBits);
         dvd_in  = {ma, {FracBits{1'b0}}};
         rem_in  = '0;
         dvs_in  = mb;
         neg_in  = neg;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DivBits-2:0], 1'b0};
         if (rsh >= {1'b0, dvs_ff}) begin
            rem_in = rsh - {1'b0, dvs_ff};
            dvd_in[0] = 1'b1;
         end else begin
            rem_in = rsh;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntBits'(1)) begin
            busy_in = 1'b0;
            res_in  = make_signed(neg_ff, |dvd_in[DivBits-1:ValueBits],
                                  dvd_in[ValueBits-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign sts.busy = busy_ff;
   assign result   = res_ff;

endmodule

// ===== hw/rtl/gaussian_elimination_solver.sv =====
// Load: words are taken while req_stall is low; rsp_* idle while loading.
// Solve: a sequencer drives one shared multiply/divide unit through forward elimination
// and back substitution, then gives n result words (one per unstalled cycle).
// Reset (synchronous): order back to 8, sequencer to load, singular cleared.
module gaussian_elimination_solver
   import ges_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [3:0]           csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [2:0]           req_elem_row,
   input  logic [3:0]           req_elem_col,
   input  logic signed [31:0]   req_elem_value,
   input  logic                 req_last_elem,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_sol_index,
   output logic signed [31:0]   rsp_sol_value,
   output logic                 rsp_singular,
   output logic                 rsp_last_result
);

   state_type             st_ff, st_in;
   logic [3:0]            order_ff;
   logic [ColBits-1:0]    n_ff, n_in;
   logic [RowBits-1:0]    k_ff, k_in, i_ff, i_in;
   logic [ColBits-1:0]    j_ff, j_in;
   value_type             c_ff, c_in, t_ff, t_in, acc_ff, acc_in, piv_ff, piv_in;
   logic                  sing_ff, sing_in;
   logic [RowBits-1:0]    oi_ff, oi_in;

   value_type             mem [Depth];
   value_type             rd_ff;
   value_type             sol [MaxOrder];
   value_type             sol_rd;
   logic [AddrBits-1:0]   rd_addr, wr_addr;
   value_type             wr_data;
   logic                  wr_en, sol_we;
   value_type             sol_wd;
   logic [RowBits-1:0]    sol_wa;

   alu_ctl_type           ctl;
   alu_sts_type           sts;
   value_type             op_a, op_b, alu_res;
   logic [ColBits-1:0]    n_eff;
   logic                  in_acc;

   ges_alu u_alu (
      .clock (clock), .reset (reset), .ctl (ctl), .op_a (op_a), .op_b (op_b),
      .sts (sts), .result (alu_res)
   );

   function automatic logic [AddrBits-1:0] addr(logic [ColBits-1:0] r, logic [ColBits-1:0] c);
      return AddrBits'(r * NCols + c);
   endfunction

   // Effective order saturated into range
   always_comb begin
      if (order_ff < 4'd2)              n_eff = ColBits'(2);
      else if (order_ff > 4'(MaxOrder)) n_eff = ColBits'(MaxOrder);
      else                              n_eff = ColBits'(order_ff);
   end

   assign req_stall = (st_ff != ST_LOAD);
   assign in_acc    = req_valid && !req_stall;

   // Next state
   always_comb begin
      st_in = st_ff; n_in = n_ff; k_in = k_ff; i_in = i_ff; j_in = j_ff;
      c_in = c_ff; t_in = t_ff; acc_in = acc_ff; piv_in = piv_ff;
      sing_in = sing_ff; oi_in = oi_ff;
      case (st_ff)
         ST_LOAD: begin
            if (in_acc && req_last_elem) begin
               n_in = n_eff; k_in = '0; sing_in = 1'b0; st_in = ST_E_PIV;
            end
         end
         ST_E_PIV: st_in = ST_E_PIVW;
         ST_E_PIVW: begin
            piv_in = rd_ff;
            i_in = k_ff + 1'b1;
            if (rd_ff == '0) begin
               sing_in = 1'b1; oi_in = '0; st_in = ST_OUT;
            end else st_in = ST_E_RDA;
         end
         ST_E_RDA: st_in = ST_E_RDAW;
         ST_E_RDAW: st_in = ST_E_DIV;
         ST_E_DIV: begin
            if (!sts.busy && !ctl.div_start) begin
               c_in = alu_res; j_in = ColBits'(k_ff); st_in = ST_E_RDJ;
            end
         end
         ST_E_RDJ: st_in = ST_E_RDJW;
         ST_E_RDJW: st_in = ST_E_MUL;
         ST_E_MUL: st_in = ST_E_RDIJ;
         ST_E_RDIJ: st_in = ST_E_RDIJW;
         ST_E_RDIJW: begin
            t_in = alu_res; st_in = ST_E_WR;
         end
         ST_E_WR: begin
            if (j_ff == n_ff) begin
               if (ColBits'(i_ff) == n_ff - 1'b1) begin
                  if (ColBits'(k_ff) + 2'd2 == n_ff) begin
                     i_in = RowBits'(n_ff - 1'b1); st_in = ST_B_RDB;
                  end else begin
                     k_in = k_ff + 1'b1; st_in = ST_E_PIV;
                  end
               end else begin
                  i_in = i_ff + 1'b1; st_in = ST_E_RDA;
               end
            end else begin
               j_in = j_ff + 1'b1; st_in = ST_E_RDJ;
            end
         end
         ST_B_RDB: st_in = ST_B_RDBW;
         ST_B_RDBW: begin
            acc_in = rd_ff; j_in = n_ff - 1'b1;
            st_in = (n_ff - 1'b1 == ColBits'(i_ff)) ? ST_B_RDD : ST_B_RDJ;
         end
         ST_B_RDJ: st_in = ST_B_RDJW;
         ST_B_RDJW: st_in = ST_B_MUL;
         ST_B_MUL: st_in = ST_B_SUB;
         ST_B_SUB: begin
            acc_in = sat_sub(acc_ff, alu_res);
            j_in = j_ff - 1'b1;
            st_in = (j_ff - 1'b1 == ColBits'(i_ff)) ? ST_B_RDD : ST_B_RDJ;
         end
         ST_B_RDD: st_in = ST_B_RDDW;
         ST_B_RDDW: begin
            piv_in = rd_ff;
            if (rd_ff == '0) begin
               sing_in = 1'b1; oi_in = '0; st_in = ST_OUT;
            end else st_in = ST_B_DIV;
         end
         ST_B_DIV: begin
            if (!sts.busy && !ctl.div_start) begin
               if (i_ff == '0) begin
                  oi_in = '0; st_in = ST_OUT;
               end else begin
                  i_in = i_ff - 1'b1; st_in = ST_B_RDB;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               if (ColBits'(oi_ff) == n_ff - 1'b1) st_in = ST_LOAD;
               else oi_in = oi_ff + 1'b1;
            end
         end
         default: st_in = ST_LOAD;
      endcase
   end

   // Outputs of the sequencer; the j-loop read addresses are held through their wait states
   always_comb begin
      rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
      ctl = '0; op_a = c_ff; op_b = rd_ff;
      sol_we = 1'b0; sol_wa = i_ff; sol_wd = alu_res;
      case (st_ff)
         ST_LOAD: begin
            wr_en = in_acc && ColBits'(req_elem_row) < n_eff && req_elem_col <= n_eff;
            wr_addr = addr(ColBits'(req_elem_row), req_elem_col);
            wr_data = req_elem_value;
         end
         ST_E_PIV:  rd_addr = addr(ColBits'(k_ff), ColBits'(k_ff));
         ST_E_RDA:  rd_addr = addr(ColBits'(i_ff), ColBits'(k_ff));
         ST_E_RDAW: begin
            ctl.div_start = 1'b1; op_a = rd_ff; op_b = piv_ff;
         end
         ST_E_RDJ, ST_E_RDJW: rd_addr = addr(ColBits'(k_ff), j_ff);
         ST_E_MUL: begin
            ctl.mul_start = 1'b1; op_a = c_ff; op_b = rd_ff;
         end
         ST_E_RDIJ, ST_E_RDIJW: rd_addr = addr(ColBits'(i_ff), j_ff);
         ST_E_WR: begin
            wr_en = 1'b1; wr_addr = addr(ColBits'(i_ff), j_ff);
            wr_data = sat_sub(rd_ff, t_ff);
         end
         ST_B_RDB:  rd_addr = addr(ColBits'(i_ff), n_ff);
         ST_B_RDJ, ST_B_RDJW: rd_addr = addr(ColBits'(i_ff), j_ff);
         ST_B_MUL: begin
            ctl.mul_start = 1'b1; op_a = rd_ff; op_b = sol_rd;
         end
         ST_B_RDD:  rd_addr = addr(ColBits'(i_ff), ColBits'(i_ff));
         ST_B_RDDW: begin
            ctl.div_start = (rd_ff != '0); op_a = acc_ff; op_b = rd_ff;
         end
         ST_B_DIV:  sol_we = !sts.busy && !ctl.div_start;
         default: ;
      endcase
   end

   assign sol_rd = sol[j_ff[RowBits-1:0]];

   // Matrix store and solution registers
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
      if (sol_we) sol[sol_wa] <= sol_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_LOAD; order_ff <= 4'd8; sing_ff <= 1'b0;
         n_ff <= ColBits'(MaxOrder); oi_ff <= '0;
      end else begin
         st_ff <= st_in; sing_ff <= sing_in; n_ff <= n_in; oi_ff <= oi_in;
         if (csr_we) order_ff <= csr_wdata;
      end
      k_ff <= k_in; i_ff <= i_in; j_ff <= j_in; c_ff <= c_in; t_ff <= t_in;
      acc_ff <= acc_in; piv_ff <= piv_in;
   end

   assign rsp_valid       = (st_ff == ST_OUT);
   assign rsp_sol_index   = oi_ff;
   assign rsp_sol_value   = sing_ff ? '0 : sol[oi_ff];
   assign rsp_singular    = sing_ff;
   assign rsp_last_result = (ColBits'(oi_ff) == n_ff - 1'b1);

endmodule

// ===== hw/rtl/ges_checker.sv =====
`include "gaussian_elimination_solver_defines.svh"
module ges_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_sol_index,
   input logic signed [31:0] rsp_sol_value,
   input logic        rsp_singular,
   input logic        rsp_last_result
);
   // Results and loading never overlap
   `GES_ASSERT_CLK(a_excl, clock, reset, rsp_valid |-> req_stall, "rsp while loading")
   // A stalled result word holds
   `GES_ASSERT_CLK(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sol_index), "rsp word changed")
   // Singular runs give zero values
   `GES_ASSERT_CLK(a_sing, clock, reset, rsp_valid && rsp_singular |-> rsp_sol_value == 0, "singular nonzero")
   // After the last word the block loads again
   `GES_ASSERT_CLK(a_done, clock, reset, rsp_valid && !rsp_stall && rsp_last_result |=> !req_stall, "no return to load")
endmodule

bind gaussian_elimination_solver ges_checker u_ges_checker (.*);

// ===== dv/gaussian_elimination_solver_test.sv =====
`timescale 1ns / 1ps

module gaussian_elimination_solver_test;
   import ges_pkg::*;

   localparam longint LimitCycles = 5_000_000;

   // one expected solution word
   typedef struct {
      logic [2:0]  index;
      value_type   value;
      logic        singular;
      logic        last;
   } solution_word_type;

   // Keeps a copy of the system store and works out each solve
   class solver_scoreboard;
      value_type         mat[MaxOrder][NCols];
      value_type         sol[MaxOrder];
      logic [3:0]        order_reg;
      solution_word_type expected_words[$];
      int                errors;

      function new();
         order_reg = 4'd8;
         errors = 0;
         foreach (mat[r, c]) mat[r][c] = '0;
         foreach (sol[i]) sol[i] = '0;
      endfunction

      function int unsigned n_eff();
         if (order_reg < 2) return 2;
         if (order_reg > MaxOrder) return MaxOrder;
         return order_reg;
      endfunction

      function void set_order(logic [3:0] v);
         order_reg = v;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      static function value_type clamp(longint v);
         if (v > longint'(VMax)) return VMax;
         if (v < longint'(VMin)) return VMin;
         return value_type'(v);
      endfunction

      static function value_type fx_mul(value_type a, value_type b);
         longint p;
         longint m;
         p = longint'(a) * longint'(b);
         m = (p < 0) ? -p : p;
         m = m >> FracBits;
         return clamp((p < 0) ? -m : m);
      endfunction

      static function value_type fx_div(value_type a, value_type b);
         longint ma;
         longint mb;
         longint q;
         if (b == 0) return '0;
         ma = (a < 0) ? -longint'(a) : longint'(a);
         mb = (b < 0) ? -longint'(b) : longint'(b);
         q = (ma << FracBits) / mb;
         return clamp(((a < 0) != (b < 0)) ? -q : q);
      endfunction

      static function value_type fx_sub(value_type a, value_type b);
         return clamp(longint'(a) - longint'(b));
      endfunction

      // forward elimination then back substitution; 0 on a zero pivot
      function bit eliminate(int n);
         value_type c;
         value_type acc;
         for (int k = 0; k + 1 < n; k++) begin
            if (mat[k][k] == 0) return 0;
            for (int i = k + 1; i < n; i++) begin
               c = fx_div(mat[i][k], mat[k][k]);
               for (int j = k; j <= n; j++)
                  mat[i][j] = fx_sub(mat[i][j], fx_mul(c, mat[k][j]));
            end
         end
         for (int i = n - 1; i >= 0; i--) begin
            acc = mat[i][n];
            if (mat[i][i] == 0) return 0;
            for (int j = n - 1; j > i; j--)
               acc = fx_sub(acc, fx_mul(mat[i][j], sol[j]));
            sol[i] = fx_div(acc, mat[i][i]);
         end
         return 1;
      endfunction

      function void note_word(logic [2:0] row, logic [3:0] col, value_type v, logic last);
         int n;
         bit ok;
         solution_word_type w;
         n = n_eff();
         if (row < n && col <= n) mat[row][col] = v;
         if (!last) return;
         ok = eliminate(n);
         if (!ok) foreach (sol[i]) sol[i] = '0;
         for (int i = 0; i < n; i++) begin
            w.index = i[2:0];
            w.value = sol[i];
            w.singular = !ok;
            w.last = (i == n - 1);
            expected_words.push_back(w);
         end
      endfunction

      function void check_word(logic [2:0] idx, value_type v, logic sing, logic last);
         solution_word_type w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word index=%0d value=%h", $realtime, idx, v);
            errors++;
            return;
         end
         w = expected_words.pop_front();
         if (idx !== w.index) begin
            $display("%0t: sol_index expected %0d actual %0d", $realtime, w.index, idx);
            errors++;
         end
         if (v !== w.value) begin
            $display("%0t: sol_value expected %h actual %h", $realtime, w.value, v);
            errors++;
         end
         if (sing !== w.singular) begin
            $display("%0t: singular expected %b actual %b", $realtime, w.singular, sing);
            errors++;
         end
         if (last !== w.last) begin
            $display("%0t: last_result expected %b actual %b", $realtime, w.last, last);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            csr_we;
   logic [3:0]      csr_wdata;
   logic            req_valid;
   logic            req_stall;
   logic [2:0]      req_elem_row;
   logic [3:0]      req_elem_col;
   logic signed [31:0] req_elem_value;
   logic            req_last_elem;
   logic            rsp_valid;
   logic            rsp_stall;
   logic [2:0]      rsp_sol_index;
   logic signed [31:0] rsp_sol_value;
   logic            rsp_singular;
   logic            rsp_last_result;

   solver_scoreboard sb;
   int     send_idle_pct;
   int     stall_pct;
   int     hold_off;
   int     words_sent;
   longint cycle_count;
   bit     written[MaxOrder][NCols];

   gaussian_elimination_solver i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_elem_row    (req_elem_row),
      .req_elem_col    (req_elem_col),
      .req_elem_value  (req_elem_value),
      .req_last_elem   (req_last_elem),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sol_index   (rsp_sol_index),
      .rsp_sol_value   (rsp_sol_value),
      .rsp_singular    (rsp_singular),
      .rsp_last_result (rsp_last_result)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // receiver stall, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_word(rsp_sol_index, rsp_sol_value, rsp_singular, rsp_last_result);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LimitCycles) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // send one word; entered and left at a falling edge
   task automatic send_word(logic [2:0] row, logic [3:0] col, value_type v, logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_elem_row <= row;
      req_elem_col <= col;
      req_elem_value <= v;
      req_last_elem <= last;
      do @(posedge clock); while (req_stall);
      sb.note_word(row, col, v, last);
      if (row < sb.n_eff() && col <= sb.n_eff()) written[row][col] = 1;
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_order(logic [3:0] v);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_order(v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic value_type pick_value(bit diag, bit allow_zero);
      value_type v;
      case ($urandom_range(0, 9))
         0: v = $urandom();
         1: v = allow_zero ? '0 : 32'sh0001_0000;
         2: v = $urandom_range(0, 1) ? VMax : VMin;
         default: begin
            v = {16'($urandom_range(1, 8)), 16'h0} | ($urandom() & 32'h0000_FFFF);
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      if (diag && !allow_zero && v == 0) v = 32'sh0002_0000;
      return v;
   endfunction

   // one system: full load, or a partial rewrite once the store is filled
   task automatic run_system(bit zero_ok);
      int n;
      int total;
      int k;
      bit full_known;
      int rows[$];
      int cols[$];
      n = sb.n_eff();
      full_known = 1;
      for (int r = 0; r < n; r++)
         for (int c = 0; c <= n; c++) if (!written[r][c]) full_known = 0;
      for (int r = 0; r < n; r++)
         for (int c = 0; c <= n; c++) begin
            rows.push_back(r);
            cols.push_back(c);
         end
      if (full_known && $urandom_range(0, 3) == 0) begin
         total = $urandom_range(1, 4);
         for (int i = 0; i < total; i++) begin
            k = $urandom_range(0, rows.size() - 1);
            send_word(3'(rows[k]), 4'(cols[k]), pick_value(rows[k] == cols[k], zero_ok),
                      i == total - 1);
         end
         return;
      end
      rows.shuffle();
      for (int i = 0; i < rows.size(); i++) begin
         cols[i] = $urandom_range(0, n);
      end
      // every entry once, in row order, with stray out-of-range words
      for (int r = 0; r < n; r++) begin
         for (int c = 0; c <= n; c++) begin
            if ($urandom_range(0, 9) == 0)
               send_word(3'($urandom_range(0, 7)), 4'($urandom_range(n + 1, 15)),
                         $urandom(), 1'b0);
            send_word(3'(r), 4'(c), pick_value(r == c, zero_ok),
                      (r == n - 1) && (c == n) && $urandom_range(0, 4) != 0);
         end
      end
      if (sb.pending() == 0 || !req_last_elem)
         send_word(3'($urandom_range(0, 7)), 4'($urandom_range(n + 1, 15)),
                   $urandom(), 1'b1);
   endtask

   task automatic random_phase(int idle, int stall, int quota);
      int orders[$];
      orders = '{0, 1, 2, 2, 2, 3, 3, 3, 4, 2, 3, 5};
      send_idle_pct = idle;
      stall_pct = stall;
      while (words_sent < quota) begin
         if ($urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 14) == 0)
               write_order($urandom_range(0, 1) ? 4'd8 : 4'd15);
            else
               write_order(4'(orders[$urandom_range(0, orders.size() - 1)]));
         end
         run_system($urandom_range(0, 4) == 0);
      end
   endtask

   initial begin
      sb = new();
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_elem_row = '0;
      req_elem_col = '0;
      req_elem_value = '0;
      req_last_elem = 1'b0;
      rsp_stall = 1'b0;
      hold_off = 0;
      send_idle_pct = 0;
      stall_pct = 0;
      words_sent = 0;
      cycle_count = 0;
      foreach (written[r, c]) written[r][c] = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed: identity system of order 2
      write_order(4'd2);
      send_word(0, 0, 32'sh0001_0000, 0);
      send_word(0, 1, 32'sh0, 0);
      send_word(0, 2, 32'sh0003_0000, 0);
      send_word(1, 0, 32'sh0, 0);
      send_word(1, 1, 32'sh0001_0000, 0);
      send_word(1, 2, -32'sh0002_0000, 1);
      // zero pivot on the first diagonal
      send_word(0, 0, 32'sh0, 1);
      // extreme values, saturation throughout
      send_word(0, 0, VMin, 0);
      send_word(0, 1, VMax, 0);
      send_word(0, 2, VMax, 0);
      send_word(1, 0, VMax, 0);
      send_word(1, 1, 32'sh0000_0001, 0);
      send_word(1, 2, VMin, 1);
      // out-of-range word still starts a solve
      send_word(3'd7, 4'd15, 32'shFFFF_FFFF, 1);
      // rewrite three entries; the rest of the store stays from the runs above
      send_word(0, 0, 32'sh0001_0000, 0);
      send_word(1, 0, 32'sh0001_0000, 0);
      send_word(1, 1, 32'sh0001_0000, 1);
      // order below range acts as 2
      write_order(4'd0);
      send_word(1, 1, 32'sh0004_8000, 1);

      random_phase(0, 0, 70);

      // receiver holds off while two systems are offered back to back
      wait_drained();
      @(negedge clock);
      hold_off = 5000;
      run_system(0);
      run_system(0);

      random_phase(52, 0, 120);
      random_phase(0, 52, 160);
      random_phase(25, 25, 200);

      wait_drained();
      if (sb.errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
